[rtl/core/lc3_pkg.sv]
// Package for the LC-3 instruction executor: types, request and status codes, opcodes.
// Used by lc3_front, lc3_back and the top level in rtl/core; depends on nothing.
package lc3_pkg;

    localparam int MemWords = 65536;
    localparam int MemAw    = $clog2(MemWords);
    localparam int QDepth   = 2;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_START = 2'd1,
        REQ_STEP  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    localparam logic [1:0] StOk     = 2'd0;
    localparam logic [1:0] StUnimpl = 2'd1;
    localparam logic [1:0] StHalted = 2'd2;

    localparam logic [15:0] KbsrAddr    = 16'hFE00;
    localparam logic [15:0] KbdrAddr    = 16'hFE02;
    localparam logic [15:0] KeyReadyBit = 16'h8000;
    localparam logic [15:0] StartReset  = 16'h3000;

    localparam logic [7:0] VecGetc = 8'h20;
    localparam logic [7:0] VecOut  = 8'h21;
    localparam logic [7:0] VecIn   = 8'h23;
    localparam logic [7:0] VecHalt = 8'h25;

    localparam logic [3:0] OpBr   = 4'h0;
    localparam logic [3:0] OpAdd  = 4'h1;
    localparam logic [3:0] OpLd   = 4'h2;
    localparam logic [3:0] OpSt   = 4'h3;
    localparam logic [3:0] OpJsr  = 4'h4;
    localparam logic [3:0] OpAnd  = 4'h5;
    localparam logic [3:0] OpLdr  = 4'h6;
    localparam logic [3:0] OpStr  = 4'h7;
    localparam logic [3:0] OpNot  = 4'h9;
    localparam logic [3:0] OpLdi  = 4'hA;
    localparam logic [3:0] OpSti  = 4'hB;
    localparam logic [3:0] OpJmp  = 4'hC;
    localparam logic [3:0] OpLea  = 4'hE;
    localparam logic [3:0] OpTrap = 4'hF;

    typedef struct packed {
        t_req        req;
        logic [15:0] addr;
        logic [15:0] data;
        logic        key_ready;
        logic [7:0]  key_char;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_FETCH,
        S_PTR,
        S_DATA,
        S_DONE
    } t_state;

endpackage

[rtl/core/lc3_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module lc3_ram #(
    parameter int Width = 16,
    parameter int Depth = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[rtl/core/lc3_front.sv]
// Front end: accepts request transfers and queues them for the execution unit.
// Depends on lc3_pkg.
module lc3_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lc3_pkg::t_item    i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output lc3_pkg::t_item    o_item
);
    lc3_pkg::t_item r_q [lc3_pkg::QDepth];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push, pop;

    assign o_ready = (r_cnt != 2'(lc3_pkg::QDepth));
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

[rtl/core/lc3_back.sv]
// Execution unit: runs one queued request against memory and registers.
// Depends on lc3_pkg and lc3_ram.
module lc3_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lc3_pkg::t_item    i_item,
    input  logic [15:0]       i_start_address,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [15:0]       o_pc_value,
    output logic              o_is_halted,
    output logic [1:0]        o_status,
    output logic              o_char_valid,
    output logic [7:0]        o_char_out,
    output logic              o_trap_event,
    output logic [7:0]        o_trap_vec,
    output logic [15:0]       o_r0_value
);
    lc3_pkg::t_state r_state, n_state;
    lc3_pkg::t_item  r_it, n_it;
    logic [15:0] r_rf [8];
    logic [15:0] r_pc, n_pc, r_ir, n_ir, r_ea, n_ea;
    logic [2:0]  r_cc;
    logic        r_halt;
    logic [lc3_pkg::MemAw-1:0] r_clr, n_clr;

    logic        r_ov;
    logic [15:0] r_opc, r_or0;
    logic        r_ohalt, r_ocv, r_ote;
    logic [1:0]  r_ost;
    logic [7:0]  r_oco, r_otv;

    logic        we;
    logic [15:0] maddr, wdata, rdata;
    logic        rf_we;
    logic [2:0]  rf_wa;
    logic [15:0] rf_wd;
    logic        set_cc, r7_we, set_halt, emit;
    logic [15:0] n_r7;
    logic [1:0]  e_st;
    logic        e_cv, e_te;
    logic [7:0]  e_co, e_tv;
    logic        out_free;
    logic [15:0] kb_word, ins;

    logic [3:0]  op;
    logic [2:0]  dr, sr1;
    logic [15:0] off9, off6, off11, imm5, bval, pc1;

    lc3_ram #(.Width(16), .Depth(lc3_pkg::MemWords)) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (maddr[lc3_pkg::MemAw-1:0]),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    assign op    = r_ir[15:12];
    assign dr    = r_ir[11:9];
    assign sr1   = r_ir[8:6];
    assign off9  = {{7{r_ir[8]}}, r_ir[8:0]};
    assign off6  = {{10{r_ir[5]}}, r_ir[5:0]};
    assign off11 = {{5{r_ir[10]}}, r_ir[10:0]};
    assign imm5  = {{11{r_ir[4]}}, r_ir[4:0]};
    assign bval  = r_ir[5] ? imm5 : r_rf[r_ir[2:0]];
    assign pc1   = r_pc;

    // A read of the keyboard status returns the word stored by that same read.
    assign kb_word = r_it.key_ready ? lc3_pkg::KeyReadyBit : 16'd0;

    assign out_free = !r_ov || i_ready;
    assign o_ready  = (r_state == lc3_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        n_it = r_it;
        n_pc = r_pc;
        n_ir = r_ir;
        n_ea = r_ea;
        n_clr = r_clr;
        we = 1'b0;
        maddr = 16'd0;
        wdata = 16'd0;
        rf_we = 1'b0;
        rf_wa = dr;
        rf_wd = 16'd0;
        set_cc = 1'b0;
        r7_we = 1'b0;
        n_r7 = r_pc;
        set_halt = 1'b0;
        emit = 1'b0;
        e_st = lc3_pkg::StOk;
        e_cv = 1'b0;
        e_co = 8'd0;
        e_te = 1'b0;
        e_tv = 8'd0;
        ins = rdata;
        unique case (r_state)
            lc3_pkg::S_CLEAR: begin
                we = 1'b1;
                maddr = 16'(r_clr);
                if (r_clr == '1) n_state = lc3_pkg::S_IDLE;
                n_clr = r_clr + 1'b1;
            end
            lc3_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_it = i_item;
                    if (i_item.req == lc3_pkg::REQ_STEP && !r_halt) begin
                        maddr = r_pc;
                        if (r_pc == lc3_pkg::KbsrAddr) begin
                            we = 1'b1;
                            wdata = i_item.key_ready ? lc3_pkg::KeyReadyBit : 16'd0;
                        end
                        n_pc = r_pc + 16'd1;
                        n_state = lc3_pkg::S_FETCH;
                    end else begin
                        n_state = lc3_pkg::S_DONE;
                    end
                end
            end
            lc3_pkg::S_FETCH: begin
                if (r_pc - 16'd1 == lc3_pkg::KbsrAddr) begin
                    ins = kb_word;
                    if (r_it.key_ready) begin
                        we = 1'b1;
                        maddr = lc3_pkg::KbdrAddr;
                        wdata = {8'd0, r_it.key_char};
                    end
                end
                n_ir = ins;
                if (ins[15:12] == lc3_pkg::OpLd || ins[15:12] == lc3_pkg::OpLdi ||
                    ins[15:12] == lc3_pkg::OpSti || ins[15:12] == lc3_pkg::OpLdr) begin
                    n_state = lc3_pkg::S_PTR;
                end else begin
                    n_state = lc3_pkg::S_DONE;
                end
                if (ins[15:12] == lc3_pkg::OpLdr)
                    n_ea = r_rf[ins[8:6]] + {{10{ins[5]}}, ins[5:0]};
                else
                    n_ea = r_pc + {{7{ins[8]}}, ins[8:0]};
            end
            lc3_pkg::S_PTR: begin
                // Read at r_ea, with the keyboard status side effect.
                maddr = r_ea;
                if (r_ea == lc3_pkg::KbsrAddr) begin
                    we = 1'b1;
                    wdata = r_it.key_ready ? lc3_pkg::KeyReadyBit : 16'd0;
                end
                n_state = lc3_pkg::S_DATA;
            end
            lc3_pkg::S_DATA: begin
                if (r_ea == lc3_pkg::KbsrAddr && r_it.key_ready) begin
                    we = 1'b1;
                    maddr = lc3_pkg::KbdrAddr;
                    wdata = {8'd0, r_it.key_char};
                end
                n_state = lc3_pkg::S_DONE;
                n_ea = (r_ea == lc3_pkg::KbsrAddr) ? kb_word : rdata;
                if (op == lc3_pkg::OpLdi) begin
                    n_ir = {lc3_pkg::OpLd, r_ir[11:0]};
                    n_state = lc3_pkg::S_PTR;
                end
            end
            lc3_pkg::S_DONE: begin
                if (out_free) begin
                    emit = 1'b1;
                    n_state = lc3_pkg::S_IDLE;
                    unique case (r_it.req)
                        lc3_pkg::REQ_WRITE: begin
                            we = 1'b1;
                            maddr = r_it.addr;
                            wdata = r_it.data;
                        end
                        lc3_pkg::REQ_START: n_pc = i_start_address;
                        lc3_pkg::REQ_NONE: ;
                        lc3_pkg::REQ_STEP: begin
                            if (r_halt) begin
                                e_st = lc3_pkg::StHalted;
                            end else begin
                                case (op)
                                    lc3_pkg::OpBr:
                                        if ((r_ir[11:9] & r_cc) != 3'd0) n_pc = pc1 + off9;
                                    lc3_pkg::OpAdd: begin
                                        rf_we = 1'b1; set_cc = 1'b1;
                                        rf_wd = r_rf[sr1] + bval;
                                    end
                                    lc3_pkg::OpAnd: begin
                                        rf_we = 1'b1; set_cc = 1'b1;
                                        rf_wd = r_rf[sr1] & bval;
                                    end
                                    lc3_pkg::OpNot: begin
                                        rf_we = 1'b1; set_cc = 1'b1;
                                        rf_wd = ~r_rf[sr1];
                                    end
                                    lc3_pkg::OpLea: begin
                                        rf_we = 1'b1; set_cc = 1'b1;
                                        rf_wd = pc1 + off9;
                                    end
                                    lc3_pkg::OpLd, lc3_pkg::OpLdr: begin
                                        rf_we = 1'b1; set_cc = 1'b1;
                                        rf_wd = r_ea;
                                    end
                                    lc3_pkg::OpSt: begin
                                        we = 1'b1; maddr = pc1 + off9; wdata = r_rf[dr];
                                    end
                                    lc3_pkg::OpStr: begin
                                        we = 1'b1; maddr = r_rf[sr1] + off6;
                                        wdata = r_rf[dr];
                                    end
                                    lc3_pkg::OpSti: begin
                                        we = 1'b1; maddr = r_ea; wdata = r_rf[dr];
                                    end
                                    lc3_pkg::OpJsr: begin
                                        r7_we = 1'b1;
                                        n_pc = r_ir[11] ? pc1 + off11 : r_rf[sr1];
                                    end
                                    lc3_pkg::OpJmp: n_pc = r_rf[sr1];
                                    lc3_pkg::OpTrap: begin
                                        r7_we = 1'b1;
                                        e_tv = r_ir[7:0];
                                        case (r_ir[7:0])
                                            lc3_pkg::VecGetc: begin
                                                rf_we = 1'b1; set_cc = 1'b1; rf_wa = 3'd0;
                                                rf_wd = {8'd0, r_it.key_char};
                                            end
                                            lc3_pkg::VecOut: begin
                                                e_cv = 1'b1; e_co = r_rf[0][7:0];
                                            end
                                            lc3_pkg::VecIn: begin
                                                rf_we = 1'b1; set_cc = 1'b1; rf_wa = 3'd0;
                                                rf_wd = {8'd0, r_it.key_char};
                                                e_cv = 1'b1; e_co = r_it.key_char;
                                            end
                                            lc3_pkg::VecHalt: set_halt = 1'b1;
                                            default: e_te = 1'b1;
                                        endcase
                                    end
                                    default: begin
                                        set_halt = 1'b1;
                                        e_st = lc3_pkg::StUnimpl;
                                    end
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: n_state = lc3_pkg::S_IDLE;
        endcase
    end

    // Loads finish in DONE: the loaded word sits in r_ea.
    always_ff @(posedge i_clk) begin
        r_it <= n_it;
        r_ir <= n_ir;
        r_ea <= n_ea;
        if (emit) begin
            r_opc   <= n_pc;
            r_ohalt <= (r_it.req == lc3_pkg::REQ_START) ? 1'b0 : (r_halt || set_halt);
            r_ost   <= e_st;
            r_ocv   <= e_cv;
            r_oco   <= e_co;
            r_ote   <= e_te;
            r_otv   <= e_tv;
            r_or0   <= (rf_we && rf_wa == 3'd0) ? rf_wd : r_rf[0];
        end
        if (!i_rst_n) begin
            r_state <= lc3_pkg::S_CLEAR;
            r_clr   <= '0;
            r_pc    <= 16'd0;
            r_cc    <= 3'd0;
            r_halt  <= 1'b1;
            r_ov    <= 1'b0;
            for (int i = 0; i < 8; i++) r_rf[i] <= 16'd0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (rf_we) r_rf[rf_wa] <= rf_wd;
            if (r7_we) r_rf[7] <= n_r7;
            if (r_state == lc3_pkg::S_IDLE || emit) r_pc <= n_pc;
            if (set_cc) begin
                if (rf_wd == 16'd0)  r_cc <= 3'b010;
                else if (rf_wd[15])  r_cc <= 3'b100;
                else                 r_cc <= 3'b001;
            end
            if (emit && r_it.req == lc3_pkg::REQ_START) r_halt <= 1'b0;
            else if (set_halt) r_halt <= 1'b1;
            if (emit) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    assign o_valid       = r_ov;
    assign o_pc_value    = r_opc;
    assign o_is_halted   = r_ohalt;
    assign o_status      = r_ost;
    assign o_char_valid  = r_ocv;
    assign o_char_out    = r_oco;
    assign o_trap_event  = r_ote;
    assign o_trap_vec    = r_otv;
    assign o_r0_value    = r_or0;
endmodule

[rtl/core/lc3_instruction_executor.sv]
// LC-3 instruction executor top level: request queue, execution unit, start register.
// Write, start and none requests, and steps while halted, go IDLE then DONE; other steps go IDLE,
// FETCH, DONE, with PTR and DATA before DONE for LD/LDR/STI and twice for LDI; the execution
// unit takes no new item until DONE has emitted its result. The queue accepts new transfers while it works.
// Reset is synchronous; afterwards a clearing pass zeroes all 65536 memory words before the
// execution unit takes any request (configuration writes are taken during it).
module lc3_instruction_executor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_load_address,
    input  logic [15:0] i_load_data,
    input  logic        i_key_ready,
    input  logic [7:0]  i_key_char,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pc_value,
    output logic        o_is_halted,
    output logic [1:0]  o_status,
    output logic        o_char_valid,
    output logic [7:0]  o_char_out,
    output logic        o_trap_event,
    output logic [7:0]  o_trap_vec,
    output logic [15:0] o_r0_value
);
    lc3_pkg::t_item in_item, q_item;
    logic           q_valid, q_ready;
    logic [15:0]    r_start;

    assign in_item.req       = lc3_pkg::t_req'(i_req_type);
    assign in_item.addr      = i_load_address;
    assign in_item.data      = i_load_data;
    assign in_item.key_ready = i_key_ready;
    assign in_item.key_char  = i_key_char;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= lc3_pkg::StartReset;
        end else if (i_cfg_valid) begin
            r_start <= i_cfg_data;
        end
    end

    lc3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    lc3_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .o_ready         (q_ready),
        .i_item          (q_item),
        .i_start_address (r_start),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pc_value      (o_pc_value),
        .o_is_halted     (o_is_halted),
        .o_status        (o_status),
        .o_char_valid    (o_char_valid),
        .o_char_out      (o_char_out),
        .o_trap_event    (o_trap_event),
        .o_trap_vec      (o_trap_vec),
        .o_r0_value      (o_r0_value)
    );
endmodule

[tb/tb_lc3_instruction_executor.sv]
// Self-checking testbench for lc3_instruction_executor: directed programs, then random
// programs with random keyboard input, bursty stimulus and result backpressure.
// Depends on lc3_pkg and the lc3_instruction_executor RTL.
module tb_lc3_instruction_executor;
    import lc3_pkg::*;

    localparam int          CycleLimit = 600000;
    localparam logic [7:0]  VecPuts    = 8'h22;
    localparam logic [7:0]  VecPutsp   = 8'h24;
    localparam logic [3:0]  OpRti      = 4'h8;
    localparam logic [3:0]  OpRsv      = 4'hD;

    typedef struct {
        logic [15:0] pc;
        logic        halted;
        logic [1:0]  st;
        logic        cvalid;
        logic [7:0]  cout;
        logic        tevent;
        logic [7:0]  tvec;
        logic [15:0] r0;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = '0;
    logic [15:0] i_load_address = '0;
    logic [15:0] i_load_data = '0;
    logic        i_key_ready = 1'b0;
    logic [7:0]  i_key_char = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_pc_value;
    logic        o_is_halted;
    logic [1:0]  o_status;
    logic        o_char_valid;
    logic [7:0]  o_char_out;
    logic        o_trap_event;
    logic [7:0]  o_trap_vec;
    logic [15:0] o_r0_value;

    lc3_instruction_executor DUT (.*);

    always #5 i_clk = ~i_clk;

    // Shadow of the core's architectural state.
    logic [15:0] mem_shadow [0:65535];
    logic [15:0] regs_shadow [0:7];
    logic [15:0] pc_shadow;
    logic [2:0]  nzp_shadow;
    logic        halt_shadow;
    logic [15:0] start_shadow;
    logic        key_now;
    logic [7:0]  char_now;

    t_res        step_results_q [$];
    int          errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_halts = 0;
    int          n_host_traps = 0;
    int          cycles = 0;
    int          burst_left = 0;
    bit          quiet_sender = 1'b0;
    bit          quiet_receiver = 1'b0;
    bit          long_hold_req = 1'b0;
    int          hold_cnt = 0;

    function automatic logic [15:0] mem_load(input logic [15:0] a);
        if (a == KbsrAddr) begin
            if (key_now) begin
                mem_shadow[KbsrAddr] = KeyReadyBit;
                mem_shadow[KbdrAddr] = {8'h00, char_now};
            end else begin
                mem_shadow[KbsrAddr] = 16'h0000;
            end
        end
        return mem_shadow[a];
    endfunction

    function automatic void reg_write(input logic [2:0] r, input logic [15:0] v);
        regs_shadow[r] = v;
        nzp_shadow = (v == 16'h0) ? 3'b010 : (v[15] ? 3'b100 : 3'b001);
    endfunction

    function automatic t_res execute_item(input t_item it);
        t_res        r;
        logic [15:0] ins, npc, off9, off6, off11, b, a, tgt;
        logic [2:0]  dr, sr1;
        r = '{default: '0};
        key_now = it.key_ready;
        char_now = it.key_char;
        case (it.req)
            REQ_WRITE: mem_shadow[it.addr] = it.data;
            REQ_START: begin
                pc_shadow = start_shadow;
                halt_shadow = 1'b0;
            end
            REQ_STEP: begin
                if (halt_shadow) begin
                    r.st = StHalted;
                end else begin
                    ins = mem_load(pc_shadow);
                    npc = pc_shadow + 16'd1;
                    dr = ins[11:9];
                    sr1 = ins[8:6];
                    off9 = {{7{ins[8]}}, ins[8:0]};
                    off6 = {{10{ins[5]}}, ins[5:0]};
                    off11 = {{5{ins[10]}}, ins[10:0]};
                    case (ins[15:12])
                        OpBr: if ((ins[11:9] & nzp_shadow) != 3'b000) npc = npc + off9;
                        OpAdd, OpAnd: begin
                            b = ins[5] ? {{11{ins[4]}}, ins[4:0]} : regs_shadow[ins[2:0]];
                            if (ins[15:12] == OpAdd) reg_write(dr, regs_shadow[sr1] + b);
                            else reg_write(dr, regs_shadow[sr1] & b);
                        end
                        OpLd: begin
                            a = npc + off9;
                            reg_write(dr, mem_load(a));
                        end
                        OpSt: begin
                            a = npc + off9;
                            mem_shadow[a] = regs_shadow[dr];
                        end
                        OpJsr: begin
                            tgt = ins[11] ? npc + off11 : regs_shadow[sr1];
                            regs_shadow[7] = npc;
                            npc = tgt;
                        end
                        OpLdr: begin
                            a = regs_shadow[sr1] + off6;
                            reg_write(dr, mem_load(a));
                        end
                        OpStr: begin
                            a = regs_shadow[sr1] + off6;
                            mem_shadow[a] = regs_shadow[dr];
                        end
                        OpNot: reg_write(dr, ~regs_shadow[sr1]);
                        OpLdi: begin
                            a = npc + off9;
                            a = mem_load(a);
                            reg_write(dr, mem_load(a));
                        end
                        OpSti: begin
                            a = npc + off9;
                            a = mem_load(a);
                            mem_shadow[a] = regs_shadow[dr];
                        end
                        OpJmp: npc = regs_shadow[sr1];
                        OpLea: reg_write(dr, npc + off9);
                        OpTrap: begin
                            regs_shadow[7] = npc;
                            r.tvec = ins[7:0];
                            if (r.tvec == VecGetc) begin
                                reg_write(3'd0, {8'h00, char_now});
                            end else if (r.tvec == VecOut) begin
                                r.cvalid = 1'b1;
                                r.cout = regs_shadow[0][7:0];
                            end else if (r.tvec == VecIn) begin
                                reg_write(3'd0, {8'h00, char_now});
                                r.cvalid = 1'b1;
                                r.cout = char_now;
                            end else if (r.tvec == VecHalt) begin
                                halt_shadow = 1'b1;
                            end else begin
                                r.tevent = 1'b1;
                                n_host_traps++;
                            end
                        end
                        default: begin
                            r.st = StUnimpl;
                            halt_shadow = 1'b1;
                        end
                    endcase
                    pc_shadow = npc;
                    if (halt_shadow) n_halts++;
                end
            end
            default: ;
        endcase
        r.pc = pc_shadow;
        r.halted = halt_shadow;
        r.r0 = regs_shadow[0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("%0t: timeout with %0d results outstanding", $time, step_results_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, quiet stretches and one long hold-off.
    always @(posedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req <= 1'b0;
            hold_cnt <= 300;
            i_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_ready <= 1'b0;
        end else if (quiet_receiver) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    function automatic void check_field(input string name, input logic [15:0] e,
                                        input logic [15:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
        end
    endfunction

    always @(negedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid && i_ready) begin
            if (step_results_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual pc %h", $time,
                         o_pc_value);
            end else begin
                e = step_results_q.pop_front();
                check_field("pc_value", e.pc, o_pc_value);
                check_field("is_halted", 16'(e.halted), 16'(o_is_halted));
                check_field("status", 16'(e.st), 16'(o_status));
                check_field("char_valid", 16'(e.cvalid), 16'(o_char_valid));
                check_field("char_out", 16'(e.cout), 16'(o_char_out));
                check_field("trap_event", 16'(e.tevent), 16'(o_trap_event));
                check_field("trap_vec", 16'(e.tvec), 16'(o_trap_vec));
                check_field("r0_value", e.r0, o_r0_value);
                n_checked++;
            end
        end
    end

    task automatic send_item(input t_item it);
        int gap;
        if (burst_left == 0) begin
            gap = quiet_sender ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_req_type <= it.req;
        i_load_address <= it.addr;
        i_load_data <= it.data;
        i_key_ready <= it.key_ready;
        i_key_char <= it.key_char;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        step_results_q.push_back(execute_item(it));
        n_sent++;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (step_results_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [15:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        start_shadow = v;
    endtask

    function automatic t_item make_item(input t_req req, input logic [15:0] a,
                                        input logic [15:0] d);
        t_item it;
        it.req = req;
        it.addr = a;
        it.data = d;
        it.key_ready = 1'($urandom_range(0, 1));
        it.key_char = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic logic [15:0] random_word(input logic [15:0] base);
        logic [3:0]  op;
        logic [15:0] w;
        int          pick;
        w = 16'($urandom);
        pick = $urandom_range(0, 15);
        if (pick == 0) return KbsrAddr;
        if (pick == 1) return KbdrAddr;
        if (pick == 2) return base + 16'($urandom_range(0, 24));
        op = w[15:12];
        if ((op == OpRti || op == OpRsv) && $urandom_range(0, 3) != 0) op = OpAdd;
        if (op == OpTrap) begin
            case ($urandom_range(0, 7))
                0: w[7:0] = VecGetc;
                1: w[7:0] = VecOut;
                2: w[7:0] = VecPuts;
                3: w[7:0] = VecIn;
                4: w[7:0] = VecPutsp;
                5: w[7:0] = VecHalt;
                default: ;
            endcase
            w[11:8] = 4'h0;
        end
        return {op, w[11:0]};
    endfunction

    task automatic run_program(input logic [15:0] words [$], input int steps);
        foreach (words[i]) send_item(make_item(REQ_WRITE, start_shadow + 16'(i), words[i]));
        send_item(make_item(REQ_START, '0, '0));
        repeat (steps) send_item(make_item(REQ_STEP, 16'($urandom), 16'($urandom)));
    endtask

    task automatic test_directed_opcodes();
        logic [15:0] prog [$];
        cfg_write(StartReset);
        prog = '{16'h1025, 16'h927F, 16'h5440, 16'h0E00, 16'hA61B, 16'hB01B,
                 16'hE9FF, 16'h2A18, 16'h3A18, 16'h4800, 16'h1FE1, 16'h41C0,
                 16'h6C42, 16'h7C43, 16'hF020, 16'hF021, 16'hF022, 16'hF023,
                 16'hF024, 16'hF099, 16'hF025};
        send_item(make_item(REQ_WRITE, 16'h3020, KbsrAddr));
        send_item(make_item(REQ_WRITE, 16'h3021, 16'h4000));
        run_program(prog, 23);
        send_item(make_item(REQ_NONE, 16'hFFFF, 16'hFFFF));
        send_item(make_item(REQ_WRITE, 16'hFFFF, 16'hFFFF));
        send_item(make_item(REQ_WRITE, 16'h0000, 16'h0000));
    endtask

    task automatic test_error_opcodes();
        logic [15:0] prog [$];
        cfg_write(16'h0000);
        prog = '{16'h8000};
        run_program(prog, 2);
        cfg_write(16'hFFFF);
        prog = '{16'hD000, 16'h0000};
        run_program(prog, 2);
        cfg_write(KbsrAddr);
        prog = '{};
        run_program(prog, 3);
    endtask

    task automatic test_long_stall();
        logic [15:0] prog [$];
        cfg_write(16'h5000);
        for (int i = 0; i < 12; i++) prog.push_back(random_word(16'h5000));
        quiet_sender = 1'b1;
        long_hold_req = 1'b1;
        run_program(prog, 16);
        quiet_sender = 1'b0;
        drain();
    endtask

    task automatic test_random_programs(input int phases);
        logic [15:0] prog [$];
        logic [15:0] start_list [5];
        int          k;
        start_list = '{16'h0000, 16'hFFFF, StartReset, KbsrAddr, 16'h0000};
        for (int p = 0; p < phases; p++) begin
            if (p % 6 == 0) begin
                start_list[4] = 16'($urandom);
                cfg_write(start_list[$urandom_range(0, 4)]);
                quiet_sender = ($urandom_range(0, 3) == 0);
                quiet_receiver = ($urandom_range(0, 3) == 0);
            end
            prog = '{};
            k = $urandom_range(4, 16);
            for (int i = 0; i < k; i++) prog.push_back(random_word(start_shadow));
            repeat ($urandom_range(0, 3)) begin
                case ($urandom_range(0, 2))
                    0: send_item(make_item(REQ_WRITE, 16'($urandom), 16'($urandom)));
                    1: send_item(make_item(REQ_NONE, 16'($urandom), 16'($urandom)));
                    default: send_item(make_item(REQ_STEP, 16'($urandom), 16'($urandom)));
                endcase
            end
            run_program(prog, k + $urandom_range(2, 8));
        end
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < 65536; i++) mem_shadow[i] = '0;
        for (int i = 0; i < 8; i++) regs_shadow[i] = '0;
        pc_shadow = '0;
        nzp_shadow = '0;
        halt_shadow = 1'b1;
        start_shadow = StartReset;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_opcodes();
        test_error_opcodes();
        test_long_stall();
        test_random_programs(30);
        drain();
        $display("Checked %0d of %0d transfers across directed and random programs.",
                 n_checked, n_sent);
        $display("Saw %0d halting steps and %0d host trap events.", n_halts, n_host_traps);
        if (errors == 0 && step_results_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[lc3_instruction_executor.f]
rtl/core/lc3_pkg.sv
rtl/core/lc3_ram.sv
rtl/core/lc3_front.sv
rtl/core/lc3_back.sv
rtl/core/lc3_instruction_executor.sv
tb/tb_lc3_instruction_executor.sv
